// ===== rtl/isl_pkg.sv =====
`timescale 1ns / 1ps

package isl_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	// port widths fixed by the item format
	localparam int OP_W    = 3;
	localparam int POS_W   = 5;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int CAP_W   = 5;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// common width for comparing positions, counts and cell indexes
	localparam int CMP_W = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_READ    = 3'd0,
		OP_COMPARE = 3'd1,
		OP_SEARCH  = 3'd2,
		OP_INSERT  = 3'd3,
		OP_DELETE  = 3'd4
	} isl_op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_RANGE    = 2'd2,
		ST_MISS     = 2'd3
	} isl_status_t;

	typedef struct packed {
		logic load_value;
		logic take_lower;
		logic take_upper;
	} isl_cell_ctl_t;

endpackage

// ===== rtl/isl_cell.sv =====
`timescale 1ns / 1ps

module isl_cell
	import isl_pkg::*;
(
	input  logic                  clk,
	input  isl_cell_ctl_t         ctl,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] lower_entry,
	input  logic [DATA_WIDTH-1:0] upper_entry,
	output logic [DATA_WIDTH-1:0] entry,
	output logic                  match
);

	logic [DATA_WIDTH-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load_value) begin
			entry_q <= value;
		end else if (ctl.take_lower) begin
			entry_q <= lower_entry;
		end else if (ctl.take_upper) begin
			entry_q <= upper_entry;
		end
	end

	assign entry = entry_q;
	assign match = (entry_q == value);

endmodule

// ===== rtl/indexed_shift_list.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// command   in         start & !busy      op, position, value
// result    out        done (one cycle)   status, found_position, read_value,
//                                         entry_count, is_empty
// config    in         cfg_we             cfg_wdata (capacity limit)
//
// one item per cycle: each cell shifts, loads or compares its entry in the
// accept cycle, and the result shows on done in the cycle after.
// busy stays low; the cell row and the search encoder keep up with any rate.
// reset clears the length count and sets the capacity limit to 16; entries
// hold no reset and are only read once written by an insert.
// the receiver cannot stall: each result is valid for exactly one cycle.
module indexed_shift_list
	import isl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [OP_W-1:0]    op,
	input  logic [POS_W-1:0]   position,
	input  logic [VALUE_W-1:0] value,
	input  logic               cfg_we,
	input  logic [CAP_W-1:0]   cfg_wdata,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [POS_W-1:0]   found_position,
	output logic [VALUE_W-1:0] read_value,
	output logic [POS_W-1:0]   entry_count,
	output logic               is_empty
);

	logic [CAP_W-1:0]       cap_q;
	logic [CNT_W-1:0]       count_q;
	logic                   done_q;
	isl_status_t            status_q;
	logic [CNT_W-1:0]       found_q;
	logic [DATA_WIDTH-1:0]  rd_q;
	logic [CNT_W-1:0]       count_out_q;

	logic [DATA_WIDTH-1:0]  v;
	logic [DATA_WIDTH-1:0]  cell_entry [DEPTH];
	logic [DEPTH-1:0]       cell_match;
	isl_cell_ctl_t          cell_ctl [DEPTH];

	logic                   accept;
	logic [CMP_W-1:0]       pos_c;
	logic [CMP_W-1:0]       cnt_c;
	logic [CMP_W-1:0]       lim_c;
	logic [CMP_W-1:0]       pos_m1;
	logic                   pos_valid;
	logic                   ins_ok;
	logic                   del_ok;
	logic [DATA_WIDTH-1:0]  entry_at_pos;
	logic [CNT_W-1:0]       found;
	logic [CNT_W-1:0]       count_next;
	isl_status_t            status_d;
	logic [DATA_WIDTH-1:0]  rd_d;
	logic [CNT_W-1:0]       found_d;

	assign v      = DATA_WIDTH'(value);
	assign accept = start && !busy;
	assign busy   = 1'b0;

	assign pos_c  = CMP_W'(position);
	assign cnt_c  = CMP_W'(count_q);
	assign lim_c  = (CMP_W'(cap_q) < CMP_W'(DEPTH)) ? CMP_W'(cap_q) : CMP_W'(DEPTH);
	assign pos_m1 = pos_c - CMP_W'(1);

	assign pos_valid = (pos_c != '0) && (pos_c <= cnt_c);
	assign ins_ok    = accept && (op == OP_INSERT) && (cnt_c < lim_c) && (pos_c <= cnt_c);
	assign del_ok    = accept && (op == OP_DELETE) && pos_valid;

	assign entry_at_pos = cell_entry[pos_m1[IDX_W-1:0]];

	// per-cell moves: insert opens a slot at the position, delete closes it
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i].load_value = ins_ok && (pos_c == CMP_W'(i));
			cell_ctl[i].take_lower = ins_ok && (CMP_W'(i) > pos_c);
			cell_ctl[i].take_upper = del_ok && (CMP_W'(i) >= pos_m1);
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [DATA_WIDTH-1:0] lower_entry;
			logic [DATA_WIDTH-1:0] upper_entry;

			if (g == 0) begin : g_first
				assign lower_entry = '0;
			end else begin : g_mid_lo
				assign lower_entry = cell_entry[g-1];
			end

			if (g == DEPTH - 1) begin : g_last
				assign upper_entry = cell_entry[g];
			end else begin : g_mid_hi
				assign upper_entry = cell_entry[g+1];
			end

			isl_cell u_cell (
				.clk         (clk),
				.ctl         (cell_ctl[g]),
				.value       (v),
				.lower_entry (lower_entry),
				.upper_entry (upper_entry),
				.entry       (cell_entry[g]),
				.match       (cell_match[g])
			);
		end
	endgenerate

	// priority encoder: lowest live matching cell wins
	always_comb begin
		found = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (cell_match[i] && (CMP_W'(i) < cnt_c)) begin
				found = CNT_W'(i + 1);
			end
		end
	end

	always_comb begin
		status_d   = ST_OK;
		rd_d       = '0;
		found_d    = '0;
		count_next = count_q;
		case (op)
			OP_READ: begin
				if (!pos_valid) begin
					status_d = ST_RANGE;
				end else begin
					rd_d = entry_at_pos;
				end
			end
			OP_COMPARE: begin
				if (!pos_valid) begin
					status_d = ST_RANGE;
				end else begin
					rd_d = entry_at_pos;
					if (entry_at_pos != v) begin
						status_d = ST_MISS;
					end
				end
			end
			OP_SEARCH: begin
				found_d  = found;
				status_d = (found == '0) ? ST_MISS : ST_OK;
			end
			OP_INSERT: begin
				if (cnt_c >= lim_c) begin
					status_d = ST_OVERFLOW;
				end else if (pos_c > cnt_c) begin
					status_d = ST_RANGE;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (!pos_valid) begin
					status_d = ST_RANGE;
				end else begin
					count_next = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				count_q <= count_next;
			end
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			found_q     <= found_d;
			rd_q        <= rd_d;
			count_out_q <= count_next;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found_position = POS_W'(found_q);
	assign read_value     = VALUE_W'(rd_q);
	assign entry_count    = POS_W'(count_out_q);
	assign is_empty       = (count_out_q == '0);

endmodule

// ===== verif/indexed_shift_list_tb.sv =====
`timescale 1ns / 1ps

module indexed_shift_list_tb;
	import isl_pkg::*;

	// op codes 5 to 7 are unused and leave the list alone
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 235;
	localparam int STALL_LIMIT     = 1000;
	localparam int PRINT_LIMIT     = 40;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [POS_W-1:0]   found_position;
		logic [VALUE_W-1:0] read_value;
		logic [POS_W-1:0]   entry_count;
		logic               is_empty;
	} list_result_t;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] value;
		logic               typed;
		list_result_t       result;
	} cmd_row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic [OP_W-1:0]    op        = '0;
	logic [POS_W-1:0]   position  = '0;
	logic [VALUE_W-1:0] value     = '0;
	logic               cfg_we    = 1'b0;
	logic [CAP_W-1:0]   cfg_wdata = '0;
	logic               busy;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [POS_W-1:0]   found_position;
	logic [VALUE_W-1:0] read_value;
	logic [POS_W-1:0]   entry_count;
	logic               is_empty;

	// travels with the item: a hand-written result replaces the predicted one
	logic         row_typed  = 1'b0;
	list_result_t row_result = '0;

	logic [VALUE_W-1:0] shadow_words [DEPTH];
	int                 shadow_len = 0;
	int                 cap_limit  = CAP_RESET;

	list_result_t pending_results [$];
	cmd_row_t     directed_rows [$];

	int fail_count     = 0;
	int items_accepted = 0;
	int results_seen   = 0;
	int cap_writes     = 0;
	int idle_cycles    = 0;
	int status_tally [4] = '{0, 0, 0, 0};

	indexed_shift_list uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.position       (position),
		.value          (value),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.status         (status),
		.found_position (found_position),
		.read_value     (read_value),
		.entry_count    (entry_count),
		.is_empty       (is_empty)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic list_result_t apply_list_op(logic [OP_W-1:0] opc,
			logic [POS_W-1:0] k, logic [VALUE_W-1:0] v);
		list_result_t r;
		int lim;
		r = '0;
		r.status = ST_OK;
		lim = (cap_limit < DEPTH) ? cap_limit : DEPTH;
		case (opc)
			OP_READ, OP_COMPARE: begin
				if (k == 0 || k > shadow_len) begin
					r.status = ST_RANGE;
				end else begin
					r.read_value = shadow_words[k - 1];
					if (opc == OP_COMPARE && r.read_value != v)
						r.status = ST_MISS;
				end
			end
			OP_SEARCH: begin
				r.status = ST_MISS;
				// walk down so the lowest matching position wins
				for (int i = shadow_len - 1; i >= 0; i--) begin
					if (shadow_words[i] == v) begin
						r.found_position = POS_W'(i + 1);
						r.status = ST_OK;
					end
				end
			end
			OP_INSERT: begin
				// overflow is checked before the position
				if (shadow_len >= lim) begin
					r.status = ST_OVERFLOW;
				end else if (k > shadow_len) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = shadow_len; i > k; i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[k] = v;
					shadow_len++;
				end
			end
			OP_DELETE: begin
				if (k == 0 || k > shadow_len) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = k - 1; i < shadow_len - 1; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_len--;
				end
			end
			default: ;
		endcase
		r.entry_count = POS_W'(shadow_len);
		r.is_empty = (shadow_len == 0);
		return r;
	endfunction

	function automatic void add_row(logic [OP_W-1:0] o, logic [POS_W-1:0] k,
			logic [VALUE_W-1:0] v);
		cmd_row_t row;
		row.op = o;
		row.position = k;
		row.value = v;
		row.typed = 1'b0;
		row.result = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_checked_row(logic [OP_W-1:0] o, logic [POS_W-1:0] k,
			logic [VALUE_W-1:0] v, isl_status_t st, logic [POS_W-1:0] found,
			logic [VALUE_W-1:0] rd, logic [POS_W-1:0] len);
		cmd_row_t row;
		row.op = o;
		row.position = k;
		row.value = v;
		row.typed = 1'b1;
		row.result = {st, found, rd, len, len == 0};
		directed_rows.push_back(row);
	endfunction

	task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
			logic [VALUE_W-1:0] want);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("%0t ns: result %0d %s: got 0x%0h, expected 0x%0h",
				$time, results_seen, what, got, want);
	endtask

	task automatic send_item(logic [OP_W-1:0] o, logic [POS_W-1:0] k,
			logic [VALUE_W-1:0] v, logic typed, list_result_t res, int gap_pct);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		position <= k;
		value <= v;
		row_typed <= typed;
		row_result <= res;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] lim);
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// result checking and prediction, both on the sampled edge
	always @(posedge clk) begin
		list_result_t want;
		list_result_t got;
		if (arst_n) begin
			if (done) begin
				got = {status, found_position, read_value, entry_count, is_empty};
				if (pending_results.size() == 0) begin
					report_mismatch("arrived with nothing expected", got.read_value, '0);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.found_position !== want.found_position)
						report_mismatch("found_position", got.found_position,
							want.found_position);
					if (got.read_value !== want.read_value)
						report_mismatch("read_value", got.read_value, want.read_value);
					if (got.entry_count !== want.entry_count)
						report_mismatch("entry_count", got.entry_count, want.entry_count);
					if (got.is_empty !== want.is_empty)
						report_mismatch("is_empty", got.is_empty, want.is_empty);
				end
				if (!$isunknown(got.status))
					status_tally[got.status]++;
				results_seen++;
			end
			if (cfg_we) begin
				cap_limit = cfg_wdata;
				cap_writes++;
			end
			if (start && !busy) begin
				want = apply_list_op(op, position, value);
				pending_results.push_back(row_typed ? row_result : want);
				items_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || cfg_we || (start && !busy)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("indexed_shift_list_tb failed");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	initial begin
		int cap_plan [PHASES];
		logic [OP_W-1:0] o;
		logic [POS_W-1:0] k;
		logic [VALUE_W-1:0] v;
		int pick;
		int len;
		int gap_pct;
		int ins_w;
		int del_w;

		// empty list: only an insert at position 0 is in range
		add_checked_row(OP_READ, 1, 0, ST_RANGE, 0, 0, 0);
		add_checked_row(OP_SEARCH, 0, 0, ST_MISS, 0, 0, 0);
		add_checked_row(OP_DELETE, 1, 0, ST_RANGE, 0, 0, 0);
		add_checked_row(OP_INSERT, 1, 32'hffff_ffff, ST_RANGE, 0, 0, 0);
		add_checked_row(OP_INSERT, 0, 32'hffff_ffff, ST_OK, 0, 0, 1);
		add_checked_row(OP_INSERT, 1, 32'h0000_0000, ST_OK, 0, 0, 2);
		add_checked_row(OP_READ, 1, 0, ST_OK, 0, 32'hffff_ffff, 2);
		add_checked_row(OP_READ, 2, 32'hffff_ffff, ST_OK, 0, 0, 2);
		add_checked_row(OP_COMPARE, 2, 0, ST_OK, 0, 0, 2);
		add_checked_row(OP_COMPARE, 1, 0, ST_MISS, 0, 32'hffff_ffff, 2);
		add_checked_row(OP_COMPARE, 0, 32'hffff_ffff, ST_RANGE, 0, 0, 2);
		add_checked_row(OP_SEARCH, 31, 32'hffff_ffff, ST_OK, 1, 0, 2);
		add_checked_row(OP_SEARCH, 0, 5, ST_MISS, 0, 0, 2);
		add_checked_row(OP_READ, 3, 0, ST_RANGE, 0, 0, 2);
		add_checked_row(OP_INSERT, 31, 7, ST_RANGE, 0, 0, 2);
		add_checked_row(OP_SPARE_FIRST, 1, 0, ST_OK, 0, 0, 2);
		add_checked_row(OP_SPARE_FIRST + 3'd2, 31, 32'hffff_ffff, ST_OK, 0, 0, 2);
		add_row(OP_INSERT, 1, 32'ha5a5_a5a5);
		add_row(OP_READ, 2, 0);
		add_row(OP_SEARCH, 0, 0);
		add_checked_row(OP_DELETE, 31, 0, ST_RANGE, 0, 0, 3);
		add_row(OP_DELETE, 1, 0);
		add_row(OP_DELETE, 2, 0);
		add_row(OP_DELETE, 1, 0);

		cap_plan = '{16, 0, 31, 1, 7, 16, 2, 0};
		cap_plan[PHASES - 1] = $urandom_range(3, 31);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].position,
				directed_rows[i].value, directed_rows[i].typed,
				directed_rows[i].result, 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(CAP_W'(cap_plan[ph]));
			// alternate filling and draining so the limits are hit both ways
			ins_w = (ph % 2 == 0) ? 45 : 12;
			del_w = (ph % 2 == 0) ? 12 : 40;
			gap_pct = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 32 == 0)
					gap_pct = (ph == PHASES - 1) ? 0 : 12 * $urandom_range(2);
				len = shadow_len;
				pick = $urandom_range(99);
				if (pick < 3) begin
					o = OP_SPARE_FIRST + 3'($urandom_range(2));
				end else if (pick < 3 + ins_w) begin
					o = OP_INSERT;
				end else if (pick < 3 + ins_w + del_w) begin
					o = OP_DELETE;
				end else begin
					case ($urandom_range(2))
						0: o = OP_READ;
						1: o = OP_COMPARE;
						default: o = OP_SEARCH;
					endcase
				end
				if ($urandom_range(9) < 8)
					k = POS_W'($urandom_range(0, len + 1));
				else
					k = POS_W'($urandom_range(0, 31));
				pick = $urandom_range(9);
				if (pick < 4 && len > 0) begin
					// reuse a stored word so compares and searches hit
					if (o == OP_COMPARE && k >= 1 && k <= len)
						v = shadow_words[k - 1];
					else
						v = shadow_words[$urandom_range(0, len - 1)];
				end else if (pick < 7) begin
					v = $urandom_range(7);
				end else if (pick == 7) begin
					v = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
				end else begin
					v = $urandom;
				end
				send_item(o, k, v, 1'b0, '0, gap_pct);
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (4) @(posedge clk);

		$display("%0d items accepted (%0d directed), %0d results checked, %0d limit writes",
			items_accepted, directed_rows.size(), results_seen, cap_writes);
		$display("results by status: ok %0d, overflow %0d, bad position %0d, miss %0d",
			status_tally[ST_OK], status_tally[ST_OVERFLOW], status_tally[ST_RANGE],
			status_tally[ST_MISS]);
		if (fail_count == 0)
			$display("indexed_shift_list_tb passed");
		else
			$display("indexed_shift_list_tb failed");
		$finish;
	end

endmodule

// ===== indexed_shift_list.f =====
rtl/isl_pkg.sv
rtl/isl_cell.sv
rtl/indexed_shift_list.sv
verif/indexed_shift_list_tb.sv
